/* rtl/assert_macros.svh */
// Assertion macros shared by the frame manager RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

/* rtl/pffm_pkg.sv */
// Package of the page fault frame manager: field widths, codes and the
// transfer and control structs. Depends on nothing.
package pffm_pkg;

  localparam int FRAMES_DEF = 32;
  localparam int TLB_DEF    = 4;
  localparam int IDX_W      = 8;
  localparam int PAGE_W     = 16;
  localparam int PID_W      = 8;
  localparam int SRC_W      = 2;
  localparam int RND_W      = 5;
  localparam int SLOT_W     = 2;
  localparam int FRAME_W    = 5;

  localparam logic REQ_FAULT = 1'b0;
  localparam logic REQ_STORE = 1'b1;

  localparam logic [SRC_W-1:0] FILL_EXEC = 2'd0;
  localparam logic [SRC_W-1:0] FILL_SWAP = 2'd1;
  localparam logic [SRC_W-1:0] FILL_ZERO = 2'd2;
  localparam logic [SRC_W-1:0] FILL_NONE = 2'd3;

  typedef struct packed {
    logic              req_type;
    logic [PAGE_W-1:0] fault_page;
    logic [PID_W-1:0]  process_id;
    logic [SRC_W-1:0]  page_source;
    logic [RND_W-1:0]  random_frame;
    logic [SLOT_W-1:0] dirty_slot;
  } in_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               was_resident;
    logic               did_evict;
    logic [PAGE_W-1:0]  victim_page;
    logic [PID_W-1:0]   victim_process;
    logic               write_back;
    logic [SRC_W-1:0]   fill_source;
    logic [SLOT_W-1:0]  slot_filled;
  } out_t;

  typedef struct packed {
    logic [PAGE_W-1:0] page;
    logic [PID_W-1:0]  pid;
    logic [IDX_W-1:0]  vidx;
    logic              found;
    logic [IDX_W-1:0]  hit_idx;
    logic              hit_dirty;
    logic              free_found;
    logic [IDX_W-1:0]  free_idx;
    logic [PAGE_W-1:0] v_page;
    logic [PID_W-1:0]  v_owner;
    logic              v_dirty;
  } token_t;

  typedef struct packed {
    logic              fill_en;
    logic [IDX_W-1:0]  fill_idx;
    logic [PAGE_W-1:0] fill_page;
    logic [PID_W-1:0]  fill_owner;
    logic              wb_en;
    logic [IDX_W-1:0]  wb_idx;
    logic              wb_val;
  } upd_t;

endpackage

/* rtl/pffm_cell.sv */
// One frame table cell: holds one frame's entry and passes the search
// token to its neighbor. Depends on pffm_pkg.
module pffm_cell import pffm_pkg::*; #(
  parameter logic [IDX_W-1:0] IDX = '0
) (
  input  logic   clk,
  input  logic   rst_n,
  input  token_t tok_in,
  output token_t tok_out,
  input  upd_t   upd
);

  logic              valid_r;
  logic              taken_r;
  logic              dirty_r;
  logic [PAGE_W-1:0] page_r;
  logic [PID_W-1:0]  owner_r;
  token_t            tok_r;
  token_t            tok_nxt;

  always_comb begin
    tok_nxt = tok_in;
    if (valid_r && page_r == tok_in.page && owner_r == tok_in.pid && !tok_in.found) begin
      tok_nxt.found     = 1'b1;
      tok_nxt.hit_idx   = IDX;
      tok_nxt.hit_dirty = dirty_r;
    end
    if (!taken_r && !tok_in.free_found) begin
      tok_nxt.free_found = 1'b1;
      tok_nxt.free_idx   = IDX;
    end
    if (tok_in.vidx == IDX) begin
      tok_nxt.v_page  = page_r;
      tok_nxt.v_owner = owner_r;
      tok_nxt.v_dirty = dirty_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      taken_r <= 1'b0;
      dirty_r <= 1'b0;
    end else begin
      if (upd.fill_en && upd.fill_idx == IDX) begin
        valid_r <= 1'b1;
        taken_r <= 1'b1;
        dirty_r <= 1'b0;
      end
      if (upd.wb_en && upd.wb_idx == IDX) begin
        dirty_r <= upd.wb_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
    if (upd.fill_en && upd.fill_idx == IDX) begin
      page_r  <= upd.fill_page;
      owner_r <= upd.fill_owner;
    end
  end

  assign tok_out = tok_r;

endmodule

/* rtl/pffm_fifo.sv */
// Replacement queue of frame indexes in load order, held in a memory.
// Depends on pffm_pkg and assert_macros.svh.
`include "assert_macros.svh"
module pffm_fifo import pffm_pkg::*; #(
  parameter int FRAMES = FRAMES_DEF,
  localparam int FW = $clog2(FRAMES),
  localparam int CW = $clog2(FRAMES + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_en,
  input  logic [FW-1:0] push_data,
  input  logic          pop_en,
  output logic [FW-1:0] head_data,
  output logic [CW-1:0] count
);

  logic [FW-1:0] mem [FRAMES];
  logic [FW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [FW-1:0] head_q_r;
  logic [FW:0]   tail_sum;
  logic [FW-1:0] tail;
  logic          push_ok;

  always_comb begin
    tail_sum = {1'b0, head_r} + (FW + 1)'(count_r);
    if (tail_sum >= (FW + 1)'(FRAMES)) begin
      tail = FW'(tail_sum - (FW + 1)'(FRAMES));
    end else begin
      tail = FW'(tail_sum);
    end
    push_ok = push_en && (count_r != CW'(FRAMES) || pop_en);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      if (pop_en) begin
        head_r <= (head_r == FW'(FRAMES - 1)) ? '0 : head_r + 1'b1;
      end
      count_r <= count_r + CW'(push_ok) - CW'(pop_en);
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[tail] <= push_data;
    end
    head_q_r <= mem[head_r];
  end

  assign head_data = head_q_r;
  assign count     = count_r;

  `ASSERT_AT(a_count_bound, clk, rst_n, count_r <= CW'(FRAMES))
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop_en && count_r == '0)

endmodule

/* rtl/page_fault_frame_manager.sv */
// Top level of the page fault frame manager: control, TLB and the cell row.
// Depends on pffm_pkg, pffm_cell, pffm_fifo and assert_macros.svh.
//
// Usage: drive in_data and raise start; the request transfer happens at an
// edge where start is high and busy is low. A page fault request then keeps
// busy high while a search token walks the row of FRAMES frame cells, one
// cell per cycle. Its result is registered once the token has left the last
// cell, and busy drops in the cycle that the result appears, so the next
// request can transfer as soon as busy is low again.
// A store hit request never raises busy and gives its result the cycle after
// its transfer, so store hits may follow each other in every cycle.
// Each result appears on out_data for exactly one cycle with out_valid high;
// the receiver cannot stall the block and must take it in that cycle.
// cfg_we with cfg_wdata writes the replacement policy (0 FIFO, 1 random);
// write it only while the block is idle.
// Reset clears all valid, dirty and allocation state, the queue and the
// TLB pointer; no clearing pass is needed, the block is ready at once.
`include "assert_macros.svh"
module page_fault_frame_manager import pffm_pkg::*; #(
  parameter int FRAMES      = FRAMES_DEF,
  parameter int TLB_ENTRIES = TLB_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata
);

  localparam int FW = $clog2(FRAMES);
  localparam int CW = $clog2(FRAMES + 1);
  localparam int TW = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_SEARCH
  } state_t;

  state_t           state_r;
  in_t              req_r;
  logic             policy_r;
  logic [FW-1:0]    cnt_r;
  logic             tlb_valid_r [TLB_ENTRIES];
  logic [FW-1:0]    tlb_frame_r [TLB_ENTRIES];
  logic             tlb_dirty_r [TLB_ENTRIES];
  logic [TW-1:0]    tlb_next_r;
  logic             out_valid_r;
  out_t             out_data_r;

  token_t           tok [FRAMES + 1];
  token_t           last;
  upd_t             upd;
  logic [FW-1:0]    rnd_tab [32];
  logic [FW-1:0]    fifo_head;
  logic [CW-1:0]    fifo_count;
  logic             use_fifo;
  logic             fin;
  logic             miss;
  logic             evict;
  logic [IDX_W-1:0] f_idx;
  logic [FW-1:0]    ff;
  logic             tv_after [TLB_ENTRIES];
  logic             inval_done;
  logic             wb_en;
  logic             f_dirty;
  logic             push_en;
  logic             pop_en;
  logic [TW-1:0]    slot_next;
  out_t             fault_res;
  out_t             store_res;
  logic [SRC_W-1:0] fill_src;

  for (genvar g = 0; g < 32; g++) begin : g_rnd
    assign rnd_tab[g] = FW'(g % FRAMES);
  end

  assign use_fifo = !policy_r && fifo_count != '0;

  always_comb begin
    tok[0]            = '0;
    tok[0].page       = req_r.fault_page;
    tok[0].pid        = req_r.process_id;
    tok[0].vidx       = IDX_W'(use_fifo ? fifo_head : rnd_tab[req_r.random_frame]);
  end

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    pffm_cell #(
      .IDX (IDX_W'(g))
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok[g]),
      .tok_out (tok[g + 1]),
      .upd     (upd)
    );
  end

  assign last = tok[FRAMES];

  always_comb begin
    fin   = state_r == ST_SEARCH && cnt_r == FW'(FRAMES - 1);
    miss  = !last.found;
    evict = miss && !last.free_found;
    if (last.found) begin
      f_idx = last.hit_idx;
    end else if (last.free_found) begin
      f_idx = last.free_idx;
    end else begin
      f_idx = last.vidx;
    end
    ff = FW'(f_idx);

    inval_done = 1'b0;
    for (int i = 0; i < TLB_ENTRIES; i++) begin
      tv_after[i] = tlb_valid_r[i];
      if (evict && last.v_owner == last.pid && !inval_done &&
          tlb_valid_r[i] && tlb_frame_r[i] == FW'(last.vidx)) begin
        tv_after[i] = 1'b0;
        inval_done  = 1'b1;
      end
    end

    wb_en   = tv_after[tlb_next_r];
    f_dirty = miss ? 1'b0 : last.hit_dirty;
    if (wb_en && tlb_frame_r[tlb_next_r] == ff) begin
      f_dirty = tlb_dirty_r[tlb_next_r];
    end

    upd.fill_en    = fin && miss;
    upd.fill_idx   = f_idx;
    upd.fill_page  = last.page;
    upd.fill_owner = last.pid;
    upd.wb_en      = fin && wb_en;
    upd.wb_idx     = IDX_W'(tlb_frame_r[tlb_next_r]);
    upd.wb_val     = tlb_dirty_r[tlb_next_r];

    push_en = fin && miss && !policy_r;
    pop_en  = fin && evict && use_fifo;

    slot_next = (tlb_next_r == TW'(TLB_ENTRIES - 1)) ? '0 : tlb_next_r + 1'b1;

    fill_src = (req_r.page_source == FILL_NONE) ? FILL_ZERO : req_r.page_source;

    fault_res                = '0;
    fault_res.frame          = f_idx[FRAME_W-1:0];
    fault_res.was_resident   = last.found;
    fault_res.did_evict      = evict;
    fault_res.victim_page    = evict ? last.v_page : '0;
    fault_res.victim_process = evict ? last.v_owner : '0;
    fault_res.write_back     = evict && last.v_dirty;
    fault_res.fill_source    = miss ? fill_src : FILL_NONE;
    fault_res.slot_filled    = SLOT_W'(tlb_next_r);

    store_res             = '0;
    store_res.fill_source = FILL_NONE;
  end

  pffm_fifo #(
    .FRAMES (FRAMES)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_en   (push_en),
    .push_data (ff),
    .pop_en    (pop_en),
    .head_data (fifo_head),
    .count     (fifo_count)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      policy_r    <= 1'b0;
      cnt_r       <= '0;
      tlb_next_r  <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TLB_ENTRIES; i++) begin
        tlb_valid_r[i] <= 1'b0;
        tlb_dirty_r[i] <= 1'b0;
      end
    end else begin
      out_valid_r <= (state_r == ST_IDLE && start && in_data.req_type == REQ_STORE) || fin;
      if (cfg_we) begin
        policy_r <= cfg_wdata;
      end
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            req_r <= in_data;
            if (in_data.req_type == REQ_STORE) begin
              if (int'(in_data.dirty_slot) < TLB_ENTRIES) begin
                tlb_dirty_r[TW'(in_data.dirty_slot)] <= 1'b1;
              end
              out_data_r <= store_res;
            end else begin
              state_r <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          cnt_r   <= '0;
          state_r <= ST_SEARCH;
        end
        ST_SEARCH: begin
          if (fin) begin
            for (int i = 0; i < TLB_ENTRIES; i++) begin
              tlb_valid_r[i] <= (i == int'(tlb_next_r)) ? 1'b1 : tv_after[i];
            end
            tlb_frame_r[tlb_next_r] <= ff;
            tlb_dirty_r[tlb_next_r] <= f_dirty;
            tlb_next_r              <= slot_next;
            out_data_r              <= fault_res;
            state_r                 <= ST_IDLE;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_AT(a_fault_done, clk, rst_n, fin |=> (out_valid_r && !busy))
  `ASSERT_AT(a_slot_range, clk, rst_n, tlb_next_r <= TW'(TLB_ENTRIES - 1))
  `ASSERT_NEVER(a_fifo_policy, clk, rst_n, policy_r && (push_en || pop_en))

endmodule

/* test/pffm_checker.sv */
// Checker of the page fault frame manager: watches request, result and policy
// transfers, predicts each result and compares it. Depends on pffm_pkg.
module pffm_checker import pffm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_data,
  input  logic out_valid,
  input  out_t out_data,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   fails,
  output int   pending,
  output int   n_faults,
  output int   n_evicts
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = FRAMES_DEF;
  localparam int NT = TLB_DEF;

  logic              policy_random;
  logic              fr_valid [NF];
  logic [PAGE_W-1:0] fr_page  [NF];
  logic [PID_W-1:0]  fr_owner [NF];
  logic              fr_dirty [NF];
  logic              fr_taken [NF];
  int                age_queue [NF];
  int                age_head;
  int                age_count;
  logic              tlb_valid [NT];
  logic [PAGE_W-1:0] tlb_page  [NT];
  int                tlb_frame [NT];
  logic              tlb_dirty [NT];
  int                tlb_next;
  out_t              expected_q [$];

  function automatic out_t resolve_request(in_t r);
    out_t o;
    int   f;
    bit   hit;
    bit   got;
    int   s;
    o = '0;
    o.fill_source = FILL_NONE;
    if (r.req_type == REQ_STORE) begin
      if (int'(r.dirty_slot) < NT) tlb_dirty[r.dirty_slot] = 1'b1;
      return o;
    end
    f = 0;
    hit = 0;
    got = 0;
    for (int i = 0; i < NF; i++) begin
      if (!hit && fr_valid[i] && fr_page[i] == r.fault_page &&
          fr_owner[i] == r.process_id) begin
        f = i;
        hit = 1;
      end
    end
    if (hit) begin
      o.was_resident = 1'b1;
    end else begin
      for (int i = 0; i < NF; i++) begin
        if (!got && !fr_taken[i]) begin
          f = i;
          got = 1;
          fr_taken[i] = 1'b1;
        end
      end
      if (!got) begin
        if (!policy_random && age_count > 0) begin
          f = age_queue[age_head] % NF;
          age_head = (age_head + 1) % NF;
          age_count--;
        end else begin
          f = r.random_frame % NF;
        end
        o.did_evict = 1'b1;
        o.victim_page = fr_page[f];
        o.victim_process = fr_owner[f];
        if (fr_owner[f] == r.process_id) begin
          for (int i = 0; i < NT; i++) begin
            if (tlb_valid[i] && tlb_frame[i] == f) begin
              tlb_valid[i] = 1'b0;
              break;
            end
          end
        end
        o.write_back = fr_dirty[f];
      end
      if (!policy_random && age_count < NF) begin
        age_queue[(age_head + age_count) % NF] = f;
        age_count++;
      end
      o.fill_source = (r.page_source == FILL_NONE) ? FILL_ZERO : r.page_source;
      fr_page[f] = r.fault_page;
      fr_valid[f] = 1'b1;
      fr_dirty[f] = 1'b0;
      fr_owner[f] = r.process_id;
    end
    s = tlb_next;
    if (tlb_valid[s]) fr_dirty[tlb_frame[s]] = tlb_dirty[s];
    tlb_page[s] = fr_page[f];
    tlb_frame[s] = f;
    tlb_valid[s] = fr_valid[f];
    tlb_dirty[s] = fr_dirty[f];
    tlb_next = (s + 1) % NT;
    o.frame = f[FRAME_W-1:0];
    o.slot_filled = s[SLOT_W-1:0];
    return o;
  endfunction

  function automatic int field_bad(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, name, exp, act);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    out_t e;
    int   bad;
    if (!rst_n) begin
      policy_random <= 1'b0;
      for (int i = 0; i < NF; i++) begin
        fr_valid[i] = 1'b0;
        fr_dirty[i] = 1'b0;
        fr_taken[i] = 1'b0;
      end
      for (int i = 0; i < NT; i++) begin
        tlb_valid[i] = 1'b0;
        tlb_dirty[i] = 1'b0;
      end
      age_head = 0;
      age_count = 0;
      tlb_next = 0;
    end else begin
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, out_data);
          fails <= fails + 1;
        end else begin
          e = expected_q.pop_front();
          bad = field_bad("frame", 32'(e.frame), 32'(out_data.frame))
              + field_bad("was_resident", 32'(e.was_resident), 32'(out_data.was_resident))
              + field_bad("did_evict", 32'(e.did_evict), 32'(out_data.did_evict))
              + field_bad("victim_page", 32'(e.victim_page), 32'(out_data.victim_page))
              + field_bad("victim_process", 32'(e.victim_process),
                          32'(out_data.victim_process))
              + field_bad("write_back", 32'(e.write_back), 32'(out_data.write_back))
              + field_bad("fill_source", 32'(e.fill_source), 32'(out_data.fill_source))
              + field_bad("slot_filled", 32'(e.slot_filled), 32'(out_data.slot_filled));
          if (bad != 0) fails <= fails + 1;
          if (e.did_evict) n_evicts <= n_evicts + 1;
        end
      end
      if (start && !busy) begin
        expected_q.push_back(resolve_request(in_data));
        if (in_data.req_type == REQ_FAULT) n_faults <= n_faults + 1;
      end
      if (cfg_we) policy_random <= cfg_wdata;
    end
    pending <= expected_q.size();
  end

  initial begin
    fails = 0;
    pending = 0;
    n_faults = 0;
    n_evicts = 0;
  end
endmodule

/* test/tb_page_fault_frame_manager.sv */
// Top of the frame manager testbench: clock, reset, request and policy
// stimulus and the verdict. Depends on pffm_pkg, pffm_checker and the RTL.
module tb_page_fault_frame_manager import pffm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W = $bits(in_t);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_t  in_data = '0;
  logic out_valid;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  int   fails;
  int   pending;
  int   n_faults;
  int   n_evicts;
  int   cycles = 0;

  logic [PAGE_W-1:0] page_pool [40];
  logic [PID_W-1:0]  pid_pool  [3];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  page_fault_frame_manager u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  pffm_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .fails(fails), .pending(pending), .n_faults(n_faults), .n_evicts(n_evicts)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_request(in_t r);
    int gap;
    in_data <= r;
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
        : ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_policy(logic v);
    start <= 1'b0;
    do @(negedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t make_fault(logic [PAGE_W-1:0] pg, logic [PID_W-1:0] pid,
                                     logic [SRC_W-1:0] src, logic [RND_W-1:0] rnd);
    in_t r;
    r = in_t'(IN_W'({$urandom, $urandom}));
    r.req_type = REQ_FAULT;
    r.fault_page = pg;
    r.process_id = pid;
    r.page_source = src;
    r.random_frame = rnd;
    return r;
  endfunction

  function automatic in_t make_store(logic [SLOT_W-1:0] s);
    in_t r;
    r = in_t'(IN_W'({$urandom, $urandom}));
    r.req_type = REQ_STORE;
    r.dirty_slot = s;
    return r;
  endfunction

  function automatic in_t random_item();
    int k;
    k = $urandom_range(0, 99);
    if (k < 12) return make_store(SLOT_W'($urandom));
    if (k < 17) return make_fault(PAGE_W'($urandom), PID_W'($urandom),
                                  SRC_W'($urandom), RND_W'($urandom));
    return make_fault(page_pool[$urandom_range(0, 39)], pid_pool[$urandom_range(0, 2)],
                      SRC_W'($urandom), RND_W'($urandom));
  endfunction

  initial begin
    for (int i = 0; i < 40; i++) page_pool[i] = PAGE_W'($urandom);
    page_pool[0] = '0;
    page_pool[1] = '1;
    pid_pool[0] = '0;
    pid_pool[1] = '1;
    pid_pool[2] = PID_W'($urandom);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_policy(1'b0);

    send_request(make_fault(16'h0000, 8'h00, FILL_EXEC, 5'd0));
    send_request(make_fault(16'hFFFF, 8'hFF, FILL_SWAP, 5'd31));
    send_request(make_fault(16'h1234, 8'h00, FILL_ZERO, 5'd0));
    send_request(make_fault(16'h4321, 8'hFF, FILL_NONE, 5'd31));
    send_request(make_fault(16'h0000, 8'h00, FILL_EXEC, 5'd0));
    send_request(make_fault(16'hFFFF, 8'h00, FILL_SWAP, 5'd0));
    for (int s = 0; s < 4; s++) send_request(make_store(SLOT_W'(s)));
    for (int i = 0; i < 30; i++) send_request(random_item());
    for (int i = 0; i < 12; i++) begin
      send_request(make_fault(PAGE_W'(16'h8000 + i), 8'h00, SRC_W'($urandom),
                              RND_W'($urandom)));
    end

    for (int ph = 0; ph < 4; ph++) begin
      set_policy(ph[0] ? 1'b0 : 1'b1);
      for (int i = 0; i < 440; i++) send_request(random_item());
    end

    start <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    $display("Ran %0d page faults with %0d evictions and store hits,", n_faults, n_evicts);
    $display("alternating FIFO and random replacement across five policy phases.");
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
